// File: rtl/core/bytea_escape_decoder_assert.svh
`ifndef BYTEA_ESCAPE_DECODER_ASSERT_SVH
`define BYTEA_ESCAPE_DECODER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BED_ASSERT_IMPL(name, c, r, ante, cons) \
  name: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
    else $error("bed: assertion failed");

// next-cycle implication, disabled in reset
`define BED_ASSERT_NEXT(name, c, r, ante, cons) \
  name: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
    else $error("bed: assertion failed");

`endif

// File: rtl/core/bed_pkg.sv
package bed_pkg;

  localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHR_QUOTE     = 8'h27;
  localparam logic [7:0] CHR_ZERO      = 8'h30;
  localparam logic [7:0] CHR_NINE      = 8'h39;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_BS    = 2'd1,
    PH_D1    = 2'd2,
    PH_D2    = 2'd3
  } phase_t;

  // one decoded request: up to four bytes, in order from data[0]
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      cnt;
    logic            last;
  } req_t;

  // octal read that stops at the first digit 8 or 9
  function automatic logic [7:0] octal_read(input logic [3:0] d1, input logic [3:0] d2,
                                            input logic [3:0] d3);
    logic [7:0] v;
    begin
      if (d1 > 4'd7) begin
        v = 8'd0;
      end else if (d2 > 4'd7) begin
        v = {5'd0, d1[2:0]};
      end else if (d3 > 4'd7) begin
        v = {2'd0, d1[2:0], d2[2:0]};
      end else begin
        v = {d1[1:0], d2[2:0], d3[2:0]};
      end
      return v;
    end
  endfunction

endpackage

// File: rtl/core/bed_front.sv
`include "bytea_escape_decoder_assert.svh"

module bed_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  bed_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_wr,
  output bed_pkg::req_t     q_wr_req
);

  bed_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]      d1_r, d1_nxt;
  logic [3:0]      d2_r, d2_nxt;
  logic            accept;
  logic            is_dig;
  logic [3:0]      dval;
  logic [7:0]      c;
  logic [7:0]      d1_chr, d2_chr;
  bed_pkg::req_t   req;

  assign accept = in_push && !q_full;
  assign c      = in_data.in_char;
  assign is_dig = (c >= bed_pkg::CHR_ZERO) && (c <= bed_pkg::CHR_NINE);
  assign dval   = 4'(c - bed_pkg::CHR_ZERO);
  assign d1_chr = bed_pkg::CHR_ZERO + {4'd0, d1_r};
  assign d2_chr = bed_pkg::CHR_ZERO + {4'd0, d2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bed_pkg::PH_PLAIN;
      d1_r    <= 4'd0;
      d2_r    <= 4'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      d1_r    <= d1_nxt;
      d2_r    <= d2_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    d1_nxt    = d1_r;
    d2_nxt    = d2_r;
    req       = '0;
    case (phase_r)
      bed_pkg::PH_PLAIN: begin
        if (c == bed_pkg::CHR_BACKSLASH) begin
          phase_nxt = bed_pkg::PH_BS;
        end else begin
          req.data[0] = c;
          req.cnt     = 3'd1;
        end
      end
      bed_pkg::PH_BS: begin
        if (c == bed_pkg::CHR_QUOTE || c == bed_pkg::CHR_BACKSLASH) begin
          req.data[0] = c;
          req.cnt     = 3'd1;
          phase_nxt   = bed_pkg::PH_PLAIN;
        end else if (is_dig) begin
          d1_nxt    = dval;
          phase_nxt = bed_pkg::PH_D1;
        end else begin
          req.data[0] = bed_pkg::CHR_BACKSLASH;
          req.data[1] = c;
          req.cnt     = 3'd2;
          phase_nxt   = bed_pkg::PH_PLAIN;
        end
      end
      bed_pkg::PH_D1: begin
        if (is_dig) begin
          d2_nxt    = dval;
          phase_nxt = bed_pkg::PH_D2;
        end else begin
          req.data[0] = bed_pkg::CHR_BACKSLASH;
          req.data[1] = d1_chr;
          req.data[2] = c;
          req.cnt     = 3'd3;
          phase_nxt   = bed_pkg::PH_PLAIN;
        end
      end
      bed_pkg::PH_D2: begin
        if (is_dig) begin
          req.data[0] = bed_pkg::octal_read(d1_r, d2_r, dval);
          req.cnt     = 3'd1;
        end else begin
          req.data[0] = bed_pkg::CHR_BACKSLASH;
          req.data[1] = d1_chr;
          req.data[2] = d2_chr;
          req.data[3] = c;
          req.cnt     = 3'd4;
        end
        phase_nxt = bed_pkg::PH_PLAIN;
      end
      default: begin
        phase_nxt = bed_pkg::PH_PLAIN;
      end
    endcase

    // a held escape means nothing was emitted this step, so flush from slot 0
    if (in_data.in_last) begin
      case (phase_nxt)
        bed_pkg::PH_BS: begin
          req.data[0] = bed_pkg::CHR_BACKSLASH;
          req.cnt     = 3'd1;
        end
        bed_pkg::PH_D1: begin
          req.data[0] = bed_pkg::CHR_BACKSLASH;
          req.data[1] = bed_pkg::CHR_ZERO + {4'd0, d1_nxt};
          req.cnt     = 3'd2;
        end
        bed_pkg::PH_D2: begin
          req.data[0] = bed_pkg::CHR_BACKSLASH;
          req.data[1] = bed_pkg::CHR_ZERO + {4'd0, d1_nxt};
          req.data[2] = bed_pkg::CHR_ZERO + {4'd0, d2_nxt};
          req.cnt     = 3'd3;
        end
        default: begin
        end
      endcase
      req.last  = 1'b1;
      phase_nxt = bed_pkg::PH_PLAIN;
    end

    if (phase_nxt == bed_pkg::PH_PLAIN) begin
      d1_nxt = 4'd0;
      d2_nxt = 4'd0;
    end
  end

  assign q_wr     = accept && (req.cnt != 3'd0);
  assign q_wr_req = req;

  `BED_ASSERT_NEXT(a_last_clears_phase, clk, rst_n, accept && in_data.in_last,
                   phase_r == bed_pkg::PH_PLAIN && d1_r == 4'd0 && d2_r == 4'd0)
  `BED_ASSERT_IMPL(a_last_emits, clk, rst_n, accept && in_data.in_last, q_wr)

endmodule

// File: rtl/core/bed_queue.sv
`include "bytea_escape_decoder_assert.svh"

module bed_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  bed_pkg::req_t wr_req,
  output logic          full,
  input  logic          rd,
  output logic          rd_valid,
  output bed_pkg::req_t rd_req
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  bed_pkg::req_t   mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_wr, do_rd;

  assign full     = (cnt_r == CntW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_req   = mem_r[rd_ptr_r];
  assign do_wr    = wr && !full;
  assign do_rd    = rd && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_req;
    end
  end

  `BED_ASSERT_IMPL(a_no_overflow, clk, rst_n, wr, !full)

endmodule

// File: rtl/core/bed_back.sv
`include "bytea_escape_decoder_assert.svh"

module bed_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  bed_pkg::req_t       head,
  output logic                head_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output bed_pkg::out_item_t  out_data
);

  logic               ov_r;
  bed_pkg::out_item_t out_r;
  logic [1:0]         idx_r;
  logic               advance;
  logic               final_byte;

  assign advance    = head_valid && (!ov_r || out_pop);
  assign final_byte = ({1'b0, idx_r} + 3'd1) == head.cnt;
  assign head_pop   = advance && final_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= 2'd0;
    end else if (advance) begin
      ov_r  <= 1'b1;
      idx_r <= final_byte ? 2'd0 : idx_r + 2'd1;
    end else if (out_pop) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r.out_byte <= head.data[idx_r];
      out_r.out_last <= head.last && final_byte;
    end
  end

  assign out_empty = !ov_r;
  assign out_data  = out_r;

  `BED_ASSERT_IMPL(a_head_nonempty, clk, rst_n, head_valid, head.cnt != 3'd0)
  `BED_ASSERT_IMPL(a_idx_in_range, clk, rst_n, head_valid, {1'b0, idx_r} < head.cnt)

endmodule

// File: rtl/core/bytea_escape_decoder.sv
// channel  dir  handshake            payload
// in_      in   in_push / in_full    bed_pkg::in_item_t  (in_char, in_last)
// out_     out  out_pop / out_empty  bed_pkg::out_item_t (out_byte, out_last)
//
// One character accepted per cycle while the request queue has room.
// Each character yields zero to four bytes; the back end sends one byte per cycle
// while the output register is empty or being popped.
// The first byte passes through the request queue and then the output register.
// Reset is synchronous, active low; it clears the queue and escape state.
// A stalled output fills the queue (QUEUE_DEPTH requests), then in_full rises.
module bytea_escape_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  bed_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output bed_pkg::out_item_t out_data
);

  logic          q_wr;
  bed_pkg::req_t q_wr_req;
  logic          q_full;
  logic          q_rd;
  logic          q_valid;
  bed_pkg::req_t q_head;

  assign in_full = q_full;

  bed_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_wr     (q_wr),
    .q_wr_req (q_wr_req)
  );

  bed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (q_wr),
    .wr_req   (q_wr_req),
    .full     (q_full),
    .rd       (q_rd),
    .rd_valid (q_valid),
    .rd_req   (q_head)
  );

  bed_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head       (q_head),
    .head_pop   (q_rd),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data)
  );

endmodule
